// ===== rtl/atkv_pkg.sv =====
// atkv_pkg: shared types and constants for the kv cache eviction block
// used by attention_topk_kv_eviction
package atkv_pkg;

   localparam int MAX_POSITIONS = 1024;
   localparam int MAX_HEADS     = 8;

   localparam int IMP_BITS   = 26;
   localparam int CFG_BITS   = 11;
   localparam int HEAD_BITS  = 3;
   localparam int ROW_BITS   = 10;
   localparam int KEY_BITS   = 10;
   localparam int HCFG_BITS  = 4;
   localparam int CSR_IDX_BITS = 3;
   localparam int WIDX_BITS  = 4;
   localparam int WORD_BITS  = 64;
   localparam int OUT_BITS   = 80;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_KV_LENGTH   = 3'd0,
      CSR_TOKEN_COUNT = 3'd1,
      CSR_HEAD_COUNT  = 3'd2,
      CSR_WINDOW      = 3'd3,
      CSR_BUDGET      = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLR,
      ST_IDLE,
      ST_PRD,
      ST_PWR,
      ST_SRD,
      ST_SEV,
      ST_MRD,
      ST_MWR,
      ST_TRD,
      ST_TEV,
      ST_ORD,
      ST_OLD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_GE,
      PH_GT,
      PH_MARK
   } phase_type;

endpackage

// ===== rtl/atkv_ram.sv =====
// atkv_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module atkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/attention_topk_kv_eviction.sv =====
// attention_topk_kv_eviction: pools attention weights into per-head importance sums
// and picks the kept kv positions; depends on atkv_pkg and atkv_ram
//
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  tdata: head, query_row, key_position, weight; tlast: final_req
// rsp      out  rsp_tvalid/rsp_tready  tdata: word_index, keep_bits, kept_total; tlast: last_word
// csr      in   csr_valid/csr_ready    csr_index, csr_wdata
//
// a weight is pooled as a read, add and write on the importance ram port
// a final item, unless all positions are kept or budget, window start or heads are zero, runs
// a threshold search per head: 28 passes over positions below the window start, plus a 64-bit
// word merge (read, write); then each word is read for the total and read, loaded, output
// after reset and after each run a clear pass over all MAX_HEADS*MAX_POSITIONS entries holds req_tready low
// csr writes are taken at any time
module attention_topk_kv_eviction #(
   parameter int WEIGHT_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // head, query_row, key_position, weight, zero fill
   input  logic [((23+WEIGHT_BITS+7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // word_index, keep_bits, kept_total, zero fill
   output logic [atkv_pkg::OUT_BITS-1:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [atkv_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [atkv_pkg::CFG_BITS-1:0] csr_wdata
);
   import atkv_pkg::*;

   localparam int DEPTH = MAX_HEADS * MAX_POSITIONS;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(MAX_POSITIONS) + 1;
   localparam int HCW   = $clog2(MAX_HEADS + 1);
   localparam int KW    = MAX_POSITIONS / 64;
   localparam int KAW   = $clog2(KW);
   localparam int KRAW  = (KW > 1) ? KAW : 1;
   localparam int KDEP  = (KW > 1) ? KW : 2;
   localparam int WCW   = $clog2(KW + 1);
   localparam int SW    = ((WEIGHT_BITS > IMP_BITS) ? WEIGHT_BITS : IMP_BITS) + 1;
   localparam int BW    = $clog2(IMP_BITS);
   localparam logic [IMP_BITS-1:0] IMP_MAX = '1;

   logic [CFG_BITS-1:0]  kv_len_ff, tok_cnt_ff, window_ff, budget_ff;
   logic [HCFG_BITS-1:0] head_cnt_ff;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic [AW-1:0]          pool_addr_ff, pool_addr_in;
   logic                   pool_en_ff, pool_en_in;
   logic                   final_ff, final_in;
   logic [WEIGHT_BITS-1:0] weight_ff, weight_in;

   logic [AW-1:0]       clr_ff, clr_in;
   logic [HCW-1:0]      h_ff, h_in;
   logic [PW-1:0]       q_ff, q_in;
   logic [PW-1:0]       cnt_ff, cnt_in;
   logic [PW-1:0]       rem_ff, rem_in;
   logic [PW-1:0]       eq_ff, eq_in;
   logic [BW-1:0]       bit_ff, bit_in;
   logic [IMP_BITS-1:0] thr_ff, thr_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WCW-1:0]      w_ff, w_in;
   logic [PW-1:0]       total_ff, total_in;

   logic [WCW-1:0]       rsp_idx_ff, rsp_idx_in;
   logic [WORD_BITS-1:0] rsp_bits_ff, rsp_bits_in;
   logic [PW-1:0]        rsp_total_ff, rsp_total_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                imp_we;
   logic [AW-1:0]       imp_waddr, imp_raddr;
   logic [IMP_BITS-1:0] imp_wdata, imp_rdata;
   logic                keep_we;
   logic [KRAW-1:0]     keep_waddr, keep_raddr;
   logic [WORD_BITS-1:0] keep_wdata, keep_rdata;

   logic [PW-1:0]  n_len, wstart, k_sel;
   logic [HCW-1:0] heads;
   logic [WCW-1:0] words;
   logic           all_keep;
   logic [PW-1:0]  wn, first_row;
   logic [HEAD_BITS-1:0]   in_head;
   logic [ROW_BITS-1:0]    in_row;
   logic [KEY_BITS-1:0]    in_key;
   logic [WEIGHT_BITS-1:0] in_weight;
   logic [SW-1:0]          sum;
   logic [IMP_BITS-1:0]    cand;
   logic                   hit, keep_now, scan_last;
   logic [PW-1:0]          cnt_nx;
   logic [WORD_BITS-1:0]   masked;
   logic [PW-1:0]          pop;
   logic [31:0]            pos;

   atkv_ram #(.WIDTH(IMP_BITS), .DEPTH(DEPTH)) u_imp_ram (
      .clock   (clock),
      .wr_en   (imp_we),
      .wr_addr (imp_waddr),
      .wr_data (imp_wdata),
      .rd_addr (imp_raddr),
      .rd_data (imp_rdata)
   );

   atkv_ram #(.WIDTH(WORD_BITS), .DEPTH(KDEP)) u_keep_ram (
      .clock   (clock),
      .wr_en   (keep_we),
      .wr_addr (keep_waddr),
      .wr_data (keep_wdata),
      .rd_addr (keep_raddr),
      .rd_data (keep_rdata)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kv_len_ff   <= CFG_BITS'(1024);
         tok_cnt_ff  <= CFG_BITS'(1);
         head_cnt_ff <= HCFG_BITS'(8);
         window_ff   <= CFG_BITS'(32);
         budget_ff   <= CFG_BITS'(256);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KV_LENGTH:   kv_len_ff   <= csr_wdata;
            CSR_TOKEN_COUNT: tok_cnt_ff  <= csr_wdata;
            CSR_HEAD_COUNT:  head_cnt_ff <= csr_wdata[HCFG_BITS-1:0];
            CSR_WINDOW:      window_ff   <= csr_wdata;
            CSR_BUDGET:      budget_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      n_len    = (32'(kv_len_ff) > 32'(MAX_POSITIONS)) ? PW'(MAX_POSITIONS) : PW'(kv_len_ff);
      heads    = (32'(head_cnt_ff) > 32'(MAX_HEADS)) ? HCW'(MAX_HEADS) : HCW'(head_cnt_ff);
      wstart   = (32'(n_len) > 32'(window_ff)) ? PW'(32'(n_len) - 32'(window_ff)) : '0;
      all_keep = 32'(budget_ff) >= 32'(n_len);
      k_sel    = (32'(budget_ff) < 32'(wstart)) ? PW'(budget_ff) : wstart;
      words    = (n_len == '0) ? WCW'(1) : WCW'((32'(n_len) + 32'd63) >> 6);
      wn       = (32'(window_ff) < 32'(tok_cnt_ff)) ? PW'(window_ff) : PW'(tok_cnt_ff);
      first_row = PW'(32'(tok_cnt_ff) - 32'(wn));
   end

   assign in_head   = req_tdata[HEAD_BITS-1:0];
   assign in_row    = req_tdata[HEAD_BITS+ROW_BITS-1:HEAD_BITS];
   assign in_key    = req_tdata[HEAD_BITS+ROW_BITS+KEY_BITS-1:HEAD_BITS+ROW_BITS];
   assign in_weight = req_tdata[23+WEIGHT_BITS-1:23];

   always_comb begin
      sum  = SW'(imp_rdata) + SW'(weight_ff);
      cand = thr_ff | (IMP_BITS'(1) << bit_ff);
      case (phase_ff)
         PH_GE:   hit = imp_rdata >= cand;
         PH_GT:   hit = imp_rdata > thr_ff;
         default: hit = 1'b0;
      endcase
      cnt_nx    = cnt_ff + PW'(hit);
      keep_now  = (imp_rdata > thr_ff) || ((imp_rdata == thr_ff) && (eq_ff < rem_ff));
      scan_last = (q_ff + PW'(1)) == wstart;
   end

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         pos = 32'(w_ff) * 32'd64 + 32'(i);
         masked[i] = (pos < 32'(n_len)) &&
                     (all_keep || (pos >= 32'(wstart)) || keep_rdata[i]);
      end
      pop = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         pop = pop + PW'(masked[i]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pool_addr_in = pool_addr_ff;
      pool_en_in   = pool_en_ff;
      final_in     = final_ff;
      weight_in    = weight_ff;
      clr_in       = clr_ff;
      h_in         = h_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      eq_in        = eq_ff;
      bit_in       = bit_ff;
      thr_in       = thr_ff;
      acc_in       = acc_ff;
      w_in         = w_ff;
      total_in     = total_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;
      imp_we       = 1'b0;
      imp_waddr    = pool_addr_ff;
      imp_wdata    = (sum > SW'(IMP_MAX)) ? IMP_MAX : sum[IMP_BITS-1:0];
      imp_raddr    = AW'(32'(h_ff) * MAX_POSITIONS + 32'(q_ff));
      keep_we      = 1'b0;
      keep_waddr   = KRAW'(q_ff >> 6);
      keep_wdata   = keep_rdata | acc_ff;
      keep_raddr   = KRAW'(w_ff);
      req_tready   = 1'b0;

      case (state_ff)
         ST_CLR: begin
            imp_we     = 1'b1;
            imp_waddr  = clr_ff;
            imp_wdata  = '0;
            keep_we    = 32'(clr_ff) < KW;
            keep_waddr = KRAW'(clr_ff);
            keep_wdata = '0;
            clr_in     = clr_ff + AW'(1);
            if (32'(clr_ff) == DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               pool_addr_in = AW'(32'(in_head) * MAX_POSITIONS + 32'(in_key));
               pool_en_in   = (32'(in_head) < 32'(heads)) && (32'(in_key) < 32'(n_len)) &&
                              (32'(in_row) >= 32'(first_row)) &&
                              (32'(in_row) < 32'(tok_cnt_ff));
               weight_in    = in_weight;
               final_in     = req_tlast;
               state_in     = ST_PRD;
            end
         end
         ST_PRD: begin
            imp_raddr = pool_addr_ff;
            state_in  = ST_PWR;
         end
         ST_PWR: begin
            imp_we   = pool_en_ff;
            w_in     = '0;
            total_in = '0;
            h_in     = '0;
            q_in     = '0;
            cnt_in   = '0;
            eq_in    = '0;
            thr_in   = '0;
            acc_in   = '0;
            bit_in   = BW'(IMP_BITS - 1);
            phase_in = PH_GE;
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (!all_keep && budget_ff != '0 && wstart != '0 && heads != '0) begin
               state_in = ST_SRD;
            end else begin
               state_in = ST_TRD;
            end
         end
         ST_SRD: begin
            state_in = ST_SEV;
         end
         ST_SEV: begin
            state_in = ST_SRD;
            q_in     = q_ff + PW'(1);
            case (phase_ff)
               PH_GE: begin
                  cnt_in = cnt_nx;
                  if (scan_last) begin
                     q_in   = '0;
                     cnt_in = '0;
                     if (cnt_nx >= k_sel) begin
                        thr_in = cand;
                     end
                     if (bit_ff == '0) begin
                        phase_in = PH_GT;
                     end else begin
                        bit_in = bit_ff - BW'(1);
                     end
                  end
               end
               PH_GT: begin
                  cnt_in = cnt_nx;
                  if (scan_last) begin
                     q_in     = '0;
                     cnt_in   = '0;
                     rem_in   = k_sel - cnt_nx;
                     eq_in    = '0;
                     acc_in   = '0;
                     phase_in = PH_MARK;
                  end
               end
               default: begin
                  q_in = q_ff;
                  acc_in[q_ff[5:0]] = keep_now;
                  if (imp_rdata == thr_ff) begin
                     eq_in = eq_ff + PW'(1);
                  end
                  if (scan_last || q_ff[5:0] == 6'd63) begin
                     state_in = ST_MRD;
                  end else begin
                     q_in = q_ff + PW'(1);
                  end
               end
            endcase
         end
         ST_MRD: begin
            keep_raddr = KRAW'(q_ff >> 6);
            state_in   = ST_MWR;
         end
         ST_MWR: begin
            keep_we = 1'b1;
            acc_in  = '0;
            if (scan_last) begin
               q_in     = '0;
               thr_in   = '0;
               bit_in   = BW'(IMP_BITS - 1);
               phase_in = PH_GE;
               h_in     = h_ff + HCW'(1);
               state_in = ((h_ff + HCW'(1)) == heads) ? ST_TRD : ST_SRD;
            end else begin
               q_in     = q_ff + PW'(1);
               state_in = ST_SRD;
            end
         end
         ST_TRD: begin
            state_in = ST_TEV;
         end
         ST_TEV: begin
            total_in = total_ff + pop;
            if ((w_ff + WCW'(1)) == words) begin
               w_in     = '0;
               state_in = ST_ORD;
            end else begin
               w_in     = w_ff + WCW'(1);
               state_in = ST_TRD;
            end
         end
         ST_ORD: begin
            state_in = ST_OLD;
         end
         ST_OLD: begin
            rsp_idx_in   = w_ff;
            rsp_bits_in  = masked;
            rsp_total_in = total_ff;
            rsp_last_in  = (w_ff + WCW'(1)) == words;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               if (rsp_last_ff) begin
                  clr_in   = '0;
                  state_in = ST_CLR;
               end else begin
                  w_in     = w_ff + WCW'(1);
                  state_in = ST_ORD;
               end
            end
         end
         default: begin
            state_in = ST_CLR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         clr_ff   <= '0;
         phase_ff <= PH_GE;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      pool_addr_ff <= pool_addr_in;
      pool_en_ff   <= pool_en_in;
      final_ff     <= final_in;
      weight_ff    <= weight_in;
      h_ff         <= h_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      rem_ff       <= rem_in;
      eq_ff        <= eq_in;
      bit_ff       <= bit_in;
      thr_ff       <= thr_in;
      acc_ff       <= acc_in;
      w_ff         <= w_in;
      total_ff     <= total_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_bits_ff  <= rsp_bits_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = state_ff == ST_OUT;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {1'b0, CFG_BITS'(rsp_total_ff), rsp_bits_ff, WIDX_BITS'(rsp_idx_ff)};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request accepted while a result is pending");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_idx_ff + WCW'(1)) == words)
      else $error("last word flag on the wrong mask word");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_total_ff <= n_len)
      else $error("kept total exceeds position count");

endmodule
